>>> rtl/mm2bh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the murmurhash2 bucket hash unit
// no dependencies

package mm2bh_pkg;

    // hash multiplier and shift amounts
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    // bucket count, a power of two
    localparam int unsigned BUCKETS  = 1024;
    localparam int unsigned BUCKET_W = 10;

    localparam int unsigned SEED_W = 14;

    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        first_word;
        logic        last_word;
        logic [7:0]  key_length;
    } t_in_item;

    typedef struct packed {
        logic [31:0]         full_hash;
        logic [BUCKET_W-1:0] bucket;
    } t_out_item;

    // top level to core
    typedef struct packed {
        logic start;
        logic out_free;
    } t_core_ctl;

    // core to top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_core_stat;

endpackage

>>> rtl/murmur2_bucket_hash_unit.sv
`timescale 1ns / 1ps
// top level of the murmurhash2 bucket hash unit: seed register, handshakes, output register
// depends on mm2bh_pkg and mm2bh_core

// Streams a key as 32-bit little-endian words and returns the 32-bit MurmurHash2 of the key
// with the configured seed, plus the hash modulo 1024 as a bucket index, once per key on its
// last word. All multiplies go through one registered 32-bit constant multiplier, one product
// per cycle, and that sets the timing: a full word takes two key multiplies, a hash multiply
// and a fold before the next word is taken, a last word of 1 to 3 bytes a tail multiply, and
// every last word then the avalanche multiply. o_in_stall stays high while a word is in work;
// a finished result sits in the output register and the next word is taken while it waits.
// The user must write the seed only while the unit is idle; the unit does not enforce it.

module murmur2_bucket_hash_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mm2bh_pkg::t_in_item           i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mm2bh_pkg::t_out_item          o_out,
    input  logic                          i_cfg_we,
    input  logic [mm2bh_pkg::SEED_W-1:0]  i_cfg_wdata
);

    logic [mm2bh_pkg::SEED_W-1:0] r_seed;
    logic                         r_out_valid;
    mm2bh_pkg::t_out_item         r_out;
    mm2bh_pkg::t_out_item         n_out;

    mm2bh_pkg::t_core_ctl  core_ctl;
    mm2bh_pkg::t_core_stat core_stat;
    logic [31:0]           core_hash;

    assign o_in_stall        = core_stat.busy;
    assign core_ctl.start    = i_in_valid && !core_stat.busy;
    assign core_ctl.out_free = !r_out_valid || !i_out_stall;

    mm2bh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_item  (i_in),
        .i_seed  (r_seed),
        .o_stat  (core_stat),
        .o_hash  (core_hash)
    );

    assign n_out.full_hash = core_hash;
    assign n_out.bucket    = mm2bh_pkg::BUCKET_W'(core_hash % mm2bh_pkg::BUCKETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (core_stat.res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/mm2bh_mul.sv
`timescale 1ns / 1ps
// shared constant multiplier: registered low 32 bits of operand times the hash multiplier
// depends on mm2bh_pkg

module mm2bh_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    output logic [31:0] o_p
);

    logic [31:0] r_p;
    logic [31:0] n_p;

    assign n_p = i_a * mm2bh_pkg::MIX_MUL;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

>>> rtl/mm2bh_core.sv
`timescale 1ns / 1ps
// hash sequencer: accumulator, word mixing, tail and avalanche steps over one multiplier
// depends on mm2bh_pkg and mm2bh_mul

module mm2bh_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mm2bh_pkg::t_core_ctl          i_ctl,
    input  mm2bh_pkg::t_in_item           i_item,
    input  logic [mm2bh_pkg::SEED_W-1:0]  i_seed,
    output mm2bh_pkg::t_core_stat         o_stat,
    output logic [31:0]                   o_hash
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MK    = 4'd1;
    localparam logic [3:0] S_MK2   = 4'd2;
    localparam logic [3:0] S_MH    = 4'd3;
    localparam logic [3:0] S_FOLD  = 4'd4;
    localparam logic [3:0] S_TAIL  = 4'd5;
    localparam logic [3:0] S_TAILW = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FIN2  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_k;
    logic [31:0] n_k;
    logic [1:0]  r_nb;
    logic [1:0]  n_nb;
    logic        r_last;
    logic        n_last;

    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] tail_mask;
    logic [31:0] fin_hash;
    logic [31:0] start_h;
    logic        res_valid;

    mm2bh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .o_p   (mul_p)
    );

    always_comb begin
        case (r_nb)
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    assign fin_hash = mul_p ^ (mul_p >> mm2bh_pkg::FIN_SHIFT_B);

    // first word reloads the accumulator from seed and length
    assign start_h = i_item.first_word
                   ? ({{(32 - mm2bh_pkg::SEED_W){1'b0}}, i_seed}
                      ^ {24'd0, i_item.key_length})
                   : r_h;

    // multiplier operand for the step in progress
    always_comb begin
        case (r_state)
            S_MK:    mul_a = r_k;
            S_MK2:   mul_a = mul_p ^ (mul_p >> mm2bh_pkg::MIX_SHIFT);
            S_MH:    mul_a = r_h;
            S_TAIL:  mul_a = r_h ^ (r_k & tail_mask);
            S_FIN:   mul_a = r_h ^ (r_h >> mm2bh_pkg::FIN_SHIFT_A);
            default: mul_a = 32'd0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_h       = r_h;
        n_k       = r_k;
        n_nb      = r_nb;
        n_last    = r_last;
        res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_h    = start_h;
                    n_k    = i_item.key_word;
                    n_nb   = i_item.word_bytes[1:0];
                    n_last = i_item.last_word;
                    // word_bytes of four and above count as a full word
                    if (i_item.word_bytes[2]) begin
                        n_state = S_MK;
                    end else if (i_item.last_word && (i_item.word_bytes[1:0] != 2'd0)) begin
                        n_state = S_TAIL;
                    end else if (i_item.last_word) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MK: begin
                n_state = S_MK2;
            end
            S_MK2: begin
                n_state = S_MH;
            end
            S_MH: begin
                n_k     = mul_p;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_h     = mul_p ^ r_k;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                n_state = S_TAILW;
            end
            S_TAILW: begin
                n_h     = mul_p;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_h = fin_hash;
                if (i_ctl.out_free) begin
                    res_valid = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ctl.out_free) begin
                    res_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= 32'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k  <= n_k;
        r_nb <= n_nb;
    end

    assign o_hash           = (r_state == S_FIN2) ? fin_hash : r_h;
    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.res_valid = res_valid;

    a_res_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> i_ctl.out_free)
        else $error("result loaded into an occupied output slot");

    a_res_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> r_last)
        else $error("result produced for a word that is not last");

    a_fin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN2) |-> ($past(r_state) == S_FIN))
        else $error("avalanche multiply step skipped");

    a_fold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> ($past(r_state, 3) == S_MK))
        else $error("word mix sequence broken");

endmodule
